// ===== rtl/core/rks_pkg.sv =====
`timescale 1ns / 1ps
// rks_pkg: shared types and constants of the record key exchange sort
// no dependencies

package rks_pkg;

	localparam int TAG_W   = 6;
	localparam int FIELD_W = 16;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RDI,
		ST_LATI,
		ST_CMP,
		ST_WRI,
		ST_ERD,
		ST_ELD,
		ST_EWAIT
	} state_t;

	typedef struct packed {
		logic               load;
		logic [TAG_W-1:0]   tag;
		logic [FIELD_W-1:0] key;
		logic               last;
		logic               ovf;
	} emit_t;

endpackage

// ===== rtl/core/rks_if.sv =====
`timescale 1ns / 1ps
// rks_if: valid/ready channels of the record key exchange sort
// depends on nothing; field widths follow the item formats

interface rks_in_if;
	logic        valid;
	logic        ready;
	logic [5:0]  record_tag;
	logic [15:0] height;
	logic [15:0] weight;
	logic        last_record;

	modport source (output valid, record_tag, height, weight, last_record, input ready);
	modport sink   (input valid, record_tag, height, weight, last_record, output ready);
endinterface

interface rks_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  out_tag;
	logic [15:0] out_key;
	logic        out_last;
	logic        overflow;

	modport source (output valid, out_tag, out_key, out_last, overflow, input ready);
	modport sink   (input valid, out_tag, out_key, out_last, overflow, output ready);
endinterface

interface rks_cfg_if;
	logic valid;
	logic ready;
	logic sort_by;

	modport source (output valid, sort_by, input ready);
	modport sink   (input valid, sort_by, output ready);
endinterface

// ===== rtl/core/rks_store.sv =====
`timescale 1ns / 1ps
// rks_store: record memory, one write port and one registered read port
// depends on nothing

module rks_store #(
	parameter int AW = 6,
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/rks_seq.sv =====
`timescale 1ns / 1ps
// rks_seq: load, exchange sort and emit sequencer over the record memory
// depends on rks_pkg, rks_if and rks_store

module rks_seq #(
	parameter int MAX_RECORDS = 64,
	parameter int KEY_BITS    = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	rks_in_if.sink         rec,
	input  logic           sort_by,
	input  logic           out_taken,
	output rks_pkg::emit_t emit
);
	import rks_pkg::*;

	localparam int AW  = $clog2(MAX_RECORDS);
	localparam int CW  = $clog2(MAX_RECORDS + 1);
	localparam int CW1 = CW + 1;
	localparam int KW  = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
	localparam int DW  = TAG_W + KW;
	localparam logic [FIELD_W-1:0] KEY_MAX = FIELD_W'((64'd1 << KW) - 64'd1);
	localparam logic [CW-1:0]      CAP     = CW'(MAX_RECORDS);

	state_t state_q, state_d;

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    n_q;
	logic [AW-1:0]    i_q, j_q, k_q;
	logic [KW-1:0]    ki_q;
	logic [TAG_W-1:0] ti_q;
	logic             dropped_q;

	logic             we;
	logic [AW-1:0]    waddr, raddr;
	logic [KW-1:0]    wkey, rd_key;
	logic [TAG_W-1:0] wtag, rd_tag;
	logic [DW-1:0]    rdata;

	logic [FIELD_W-1:0] sel;
	logic [KW-1:0]      key_in;
	logic               accept, has_room, swap, j_more, i_more, k_last;
	logic [CW-1:0]      n_next;

	rks_store #(.AW(AW), .DW(DW)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({wtag, wkey}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_tag = rdata[DW-1:KW];
	assign rd_key = rdata[KW-1:0];

	assign sel      = sort_by ? rec.weight : rec.height;
	assign key_in   = (sel > KEY_MAX) ? KEY_MAX[KW-1:0] : sel[KW-1:0];
	assign rec.ready = (state_q == ST_LOAD);
	assign accept   = rec.valid && rec.ready;
	assign has_room = (count_q < CAP);
	assign n_next   = has_room ? count_q + CW'(1) : count_q;
	assign swap     = (ki_q < rd_key);
	assign j_more   = (CW'(j_q) + CW'(1) < n_q);
	assign i_more   = (CW1'(i_q) + CW1'(2) < CW1'(n_q));
	assign k_last   = (CW'(k_q) + CW'(1) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		waddr     = i_q;
		wkey      = ki_q;
		wtag      = ti_q;
		raddr     = i_q;
		emit      = '0;
		emit.tag  = rd_tag;
		emit.key  = FIELD_W'(rd_key);
		emit.last = k_last;
		emit.ovf  = dropped_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && has_room) begin
					we    = 1'b1;
					waddr = count_q[AW-1:0];
					wkey  = key_in;
					wtag  = rec.record_tag;
				end
				if (accept && rec.last_record) begin
					state_d = (n_next > CW'(1)) ? ST_RDI : ST_ERD;
				end
			end
			ST_RDI: begin
				state_d = ST_LATI;
			end
			ST_LATI: begin
				raddr   = i_q + AW'(1);
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (swap) begin
					we    = 1'b1;
					waddr = j_q;
				end
				if (j_more) begin
					raddr = j_q + AW'(1);
				end else begin
					state_d = ST_WRI;
				end
			end
			ST_WRI: begin
				we      = 1'b1;
				state_d = i_more ? ST_RDI : ST_ERD;
			end
			ST_ERD: begin
				raddr   = k_q;
				state_d = ST_ELD;
			end
			ST_ELD: begin
				emit.load = 1'b1;
				state_d   = ST_EWAIT;
			end
			ST_EWAIT: begin
				if (out_taken) begin
					state_d = k_last ? ST_LOAD : ST_ERD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			n_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						count_q <= n_next;
						if (!has_room) begin
							dropped_q <= 1'b1;
						end
						if (rec.last_record) begin
							n_q <= n_next;
							i_q <= '0;
							k_q <= '0;
						end
					end
				end
				ST_LATI: begin
					j_q <= i_q + AW'(1);
				end
				ST_CMP: begin
					if (j_more) begin
						j_q <= j_q + AW'(1);
					end
				end
				ST_WRI: begin
					i_q <= i_q + AW'(1);
					k_q <= '0;
				end
				ST_EWAIT: begin
					if (out_taken) begin
						if (k_last) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
						end else begin
							k_q <= k_q + AW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// the entry at i travels in registers through the inner pass
	always_ff @(posedge clk) begin
		if (state_q == ST_LATI || (state_q == ST_CMP && swap)) begin
			ki_q <= rd_key;
			ti_q <= rd_tag;
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP)
		else $error("record count above capacity");

	a_j_above_i: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (j_q > i_q) && (CW'(j_q) < n_q))
		else $error("inner index out of range");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ERD) |-> (CW'(k_q) < n_q) && (n_q != '0))
		else $error("emit index beyond set");

	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EWAIT && out_taken && k_last) |=> (count_q == '0) && !dropped_q)
		else $error("load state not cleared after run");

endmodule

// ===== rtl/core/record_key_exchange_sort.sv =====
`timescale 1ns / 1ps
// record_key_exchange_sort: top level, config register and result output register
// depends on rks_pkg, rks_if and rks_seq

// Records load at one item per cycle while loading, into a single-port-read record
// memory. When the item marked last arrives the set of n records is sorted in
// place: each outer pass reads entry i, then compares one entry j per cycle and
// writes it back on a swap, paced by the one read port of the memory. Each result
// is then read and held in the output register until taken before the next is
// read, and no new record is taken until the last result of the run has left.
// sort_by is sampled as each record loads.

module record_key_exchange_sort #(
	parameter int MAX_RECORDS = 64,
	parameter int KEY_BITS    = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	rks_in_if.sink     rec,
	rks_out_if.source  res,
	rks_cfg_if.sink    cfg
);
	import rks_pkg::*;

	logic  sort_by_q;
	emit_t emit;
	logic  out_taken;

	assign cfg.ready = 1'b1;
	assign out_taken = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_by_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			sort_by_q <= cfg.sort_by;
		end
	end

	rks_seq #(
		.MAX_RECORDS (MAX_RECORDS),
		.KEY_BITS    (KEY_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (rec),
		.sort_by   (sort_by_q),
		.out_taken (out_taken),
		.emit      (emit)
	);

	logic               out_valid_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [FIELD_W-1:0] out_key_q;
	logic               out_last_q;
	logic               overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (out_taken) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_tag_q  <= emit.tag;
			out_key_q  <= emit.key;
			out_last_q <= emit.last;
			overflow_q <= emit.ovf;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.out_tag  = out_tag_q;
	assign res.out_key  = out_key_q;
	assign res.out_last = out_last_q;
	assign res.overflow = overflow_q;

endmodule

// ===== verif/rks_sort_checker.sv =====
`timescale 1ns / 1ps
// rks_sort_checker: watches the record, result and config channels, ranks each set
// and compares every result item; depends on rks_pkg and rks_if

module rks_sort_checker #(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	rks_in_if    rec,
	rks_out_if   res,
	rks_cfg_if   cfg,
	output int   mismatches,
	output int   outstanding
);
	import rks_pkg::*;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [FIELD_W-1:0] key;
	} slot_t;

	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [FIELD_W-1:0] key;
		logic               last;
		logic               ovf;
	} ranked_t;

	slot_t   set_records[$];
	ranked_t ranked_results[$];
	logic    key_is_weight;
	logic    records_lost;
	int      fail_count;

	// exchange sort, descending; ties keep the order this pass gives them
	function automatic void rank_set();
		slot_t   held;
		ranked_t r;
		int      n;
		n = set_records.size();
		for (int i = 0; i < n; i++) begin
			for (int j = i; j < n; j++) begin
				if (set_records[i].key < set_records[j].key) begin
					held           = set_records[i];
					set_records[i] = set_records[j];
					set_records[j] = held;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			r.tag  = set_records[k].tag;
			r.key  = set_records[k].key;
			r.last = (k == n - 1);
			r.ovf  = records_lost;
			ranked_results.push_back(r);
		end
		set_records.delete();
		records_lost = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_t   s;
		ranked_t got;
		ranked_t want;
		if (!arst_n) begin
			set_records.delete();
			ranked_results.delete();
			key_is_weight = 1'b0;
			records_lost  = 1'b0;
			fail_count    = 0;
			mismatches   <= 0;
			outstanding  <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				key_is_weight = cfg.sort_by;
			if (rec.valid && rec.ready) begin
				if (set_records.size() < CAPACITY) begin
					s.tag = rec.record_tag;
					s.key = key_is_weight ? rec.weight : rec.height;
					set_records.push_back(s);
				end else begin
					records_lost = 1'b1;
				end
				if (rec.last_record)
					rank_set();
			end
			if (res.valid && res.ready) begin
				got.tag  = res.out_tag;
				got.key  = res.out_key;
				got.last = res.out_last;
				got.ovf  = res.overflow;
				if (ranked_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected item, got tag %0d key %h last %b ovf %b",
						$time, got.tag, got.key, got.last, got.ovf);
				end else begin
					want = ranked_results.pop_front();
					if (got.tag !== want.tag || got.key !== want.key ||
						got.last !== want.last || got.ovf !== want.ovf) begin
						fail_count++;
						$display("%0t: mismatch, expected tag %0d key %h last %b ovf %b, got tag %0d key %h last %b ovf %b",
							$time, want.tag, want.key, want.last, want.ovf,
							got.tag, got.key, got.last, got.ovf);
					end
				end
			end
			mismatches  <= fail_count;
			outstanding <= ranked_results.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: stimulus and verdict for record_key_exchange_sort
// depends on rks_pkg, rks_if, the block itself and rks_sort_checker

module tb;

	localparam int CAPACITY    = 64;
	localparam int RAND_ITEMS  = 500;
	localparam int IDLE_LIMIT  = 20000;
	localparam int SETTLE      = 8;
	localparam int TAIL        = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT     = 150;

	typedef enum int {
		KEYS_SPREAD,
		KEYS_CLUSTERED,
		KEYS_EXTREME
	} key_mix_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	bit   steady_send;

	rks_in_if  rec_ch ();
	rks_out_if res_ch ();
	rks_cfg_if cfg_ch ();

	record_key_exchange_sort #(
		.MAX_RECORDS(CAPACITY),
		.KEY_BITS   (16)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rec   (rec_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	rks_sort_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.rec        (rec_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic offer_record(input logic [5:0] tag, input logic [15:0] h,
		input logic [15:0] w, input logic last);
		int gap;
		gap = steady_send ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			rec_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_ch.valid       <= 1'b1;
		rec_ch.record_tag  <= tag;
		rec_ch.height      <= h;
		rec_ch.weight      <= w;
		rec_ch.last_record <= last;
		do @(posedge clk); while (!rec_ch.ready);
	endtask

	task automatic write_sort_by(input logic v);
		rec_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
		cfg_ch.valid   <= 1'b1;
		cfg_ch.sort_by <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [15:0] draw_key(input key_mix_t mix);
		logic [15:0] v;
		case (mix)
			KEYS_CLUSTERED: v = 16'($urandom_range(0, 3));
			KEYS_EXTREME: begin
				case ($urandom_range(0, 3))
					0:       v = 16'h0000;
					1:       v = 16'hFFFF;
					2:       v = 16'h8000;
					default: v = 16'h7FFF;
				endcase
			end
			default: v = 16'($urandom_range(0, 65535));
		endcase
		return v;
	endfunction

	task automatic offer_set(input int size, input key_mix_t mix);
		steady_send = ($urandom_range(0, 3) == 0);
		for (int k = 0; k < size; k++) begin
			// occasional key select change part way through a set
			if (size > 1 && k == size / 2 && $urandom_range(0, 7) == 0)
				write_sort_by(1'($urandom_range(0, 1)));
			offer_record(6'($urandom_range(0, 63)), draw_key(mix), draw_key(mix),
				k == size - 1);
		end
	endtask

	initial begin
		int sent;
		int set_no;
		int size;
		arst_n             <= 1'b0;
		rec_ch.valid       <= 1'b0;
		rec_ch.record_tag  <= '0;
		rec_ch.height      <= '0;
		rec_ch.weight      <= '0;
		rec_ch.last_record <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.sort_by     <= 1'b0;
		steady_send = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single record set
		write_sort_by(1'b0);
		offer_record(6'd63, 16'hFFFF, 16'h0000, 1'b1);
		// height keys with extremes and a tie
		offer_record(6'd0,  16'h0000, 16'hFFFF, 1'b0);
		offer_record(6'd21, 16'h8000, 16'h1234, 1'b0);
		offer_record(6'd42, 16'h8000, 16'h0000, 1'b0);
		offer_record(6'd63, 16'hFFFF, 16'hFFFF, 1'b0);
		offer_record(6'd10, 16'h0001, 16'h8000, 1'b1);
		// weight keys
		write_sort_by(1'b1);
		offer_record(6'd5, 16'h0000, 16'h0010, 1'b0);
		offer_record(6'd6, 16'hFFFF, 16'h0010, 1'b0);
		offer_record(6'd7, 16'h0001, 16'hFFFF, 1'b0);
		offer_record(6'd8, 16'h0002, 16'h0000, 1'b1);
		// key select changed part way through a set
		offer_record(6'd30, 16'h0100, 16'h0200, 1'b0);
		offer_record(6'd31, 16'h0300, 16'h0050, 1'b0);
		write_sort_by(1'b0);
		offer_record(6'd32, 16'h0250, 16'h0001, 1'b0);
		offer_record(6'd33, 16'h0000, 16'hFFFF, 1'b1);

		sent   = 0;
		set_no = 0;
		while (sent < RAND_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				write_sort_by(1'($urandom_range(0, 1)));
			case (set_no)
				2:       size = CAPACITY;
				5:       size = CAPACITY + 1;
				9:       size = CAPACITY + 6;
				default: size = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
						: $urandom_range(1, 12);
			endcase
			offer_set(size, key_mix_t'($urandom_range(0, 2)));
			sent += size;
			set_no++;
		end
		rec_ch.valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// result side, with one long hold-off mid run while the sender is offering
	initial begin
		int stall;
		int taken;
		bit steady_recv;
		bit held;
		taken       = 0;
		steady_recv = 1'b0;
		held        = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 40 == 0)
				steady_recv = ($urandom_range(0, 2) == 0);
			if (!held && taken >= HOLD_AT && rec_ch.valid && !res_ch.out_last) begin
				stall = HOLD_CYCLES;
				held  = 1'b1;
			end else begin
				stall = steady_recv ? 0 : $urandom_range(0, 9);
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			taken++;
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((rec_ch.valid && rec_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
